@@ rtl/core/kvt_pkg.sv @@
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the key/value pair tokenizer.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int KLEN_W = 6;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_BS    = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic              flush;
        logic [KLEN_W-1:0] klen;
        logic              has_val;
        logic [7:0]        val;
        logic              has_end;
    } cmd_t;

endpackage

@@ rtl/core/key_value_pair_tokenizer.sv @@
// ----------------------------------------------------------------------------
// key_value_pair_tokenizer
// Splits a character stream into key=value pairs with quoted and escaped
// values.
// ----------------------------------------------------------------------------
// The parser takes one character word per cycle while its four-entry command
// queue has room; it pauses before writing a new key only while an earlier
// key is still being replayed. The output sequencer handles each key byte as
// a registered key store read followed by a load of the output, a value byte
// as a queue pop followed by a load, and a pair end either as one more load
// after the last value byte or, when it arrives on its own, as a pop, an
// empty value slot and a load; any load waits while the output is stalled.
// Parsing stops after an empty key until the word marked last.
module key_value_pair_tokenizer #(
    parameter int KEY_LEN   = 32,
    parameter int VALUE_LEN = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] out_kind
    output logic       m_tlast
);

    import kvt_pkg::*;

    localparam int QDEPTH = 4;
    localparam int KDEPTH = KEY_LEN - 1;
    localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;

    cmd_t           push_cmd;
    cmd_t           pop_cmd;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    logic           flush_done;
    logic           key_we;
    logic [KAW-1:0] key_waddr;
    logic [7:0]     key_wdata;
    logic [KAW-1:0] key_raddr;
    logic [7:0]     key_rdata;

    kvt_front #(
        .KEY_LEN   (KEY_LEN),
        .VALUE_LEN (VALUE_LEN),
        .QDEPTH    (QDEPTH),
        .KAW       (KAW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .cmd        (push_cmd),
        .q_full     (q_full),
        .flush_done (flush_done),
        .key_we     (key_we),
        .key_waddr  (key_waddr),
        .key_wdata  (key_wdata)
    );

    kvt_ram #(
        .WIDTH (8),
        .DEPTH (KDEPTH),
        .AW    (KAW)
    ) u_key_store (
        .aclk  (aclk),
        .we    (key_we && s_tvalid && s_tready),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kvt_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_cmd),
        .full    (q_full),
        .pop     (pop),
        .dout    (pop_cmd),
        .empty   (q_empty)
    );

    kvt_back #(
        .KAW (KAW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (pop_cmd),
        .q_empty    (q_empty),
        .pop        (pop),
        .flush_done (flush_done),
        .key_raddr  (key_raddr),
        .key_rdata  (key_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

@@ rtl/core/kvt_ram.sv @@
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/kvt_fifo.sv @@
// ----------------------------------------------------------------------------
// kvt_fifo
// Small register queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module kvt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/kvt_front.sv @@
// ----------------------------------------------------------------------------
// kvt_front
// Character parser: tracks the pair syntax, writes key bytes into the key
// store and queues one output command for each word that yields results.
// ----------------------------------------------------------------------------
module kvt_front #(
    parameter int KEY_LEN   = 32,
    parameter int VALUE_LEN = 256,
    parameter int QDEPTH    = 4,
    parameter int KAW       = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    output logic                push,
    output kvt_pkg::cmd_t       cmd,
    input  logic                q_full,
    input  logic                flush_done,
    output logic                key_we,
    output logic [KAW-1:0]      key_waddr,
    output logic [7:0]          key_wdata
);

    import kvt_pkg::*;

    localparam int KCW = $clog2(KEY_LEN);
    localparam int VCW = $clog2(VALUE_LEN);
    localparam int PW  = $clog2(QDEPTH + 1);

    localparam logic [2:0] PH_SKIP   = 3'd0;
    localparam logic [2:0] PH_KEY    = 3'd1;
    localparam logic [2:0] PH_KDROP  = 3'd2;
    localparam logic [2:0] PH_VSTART = 3'd3;
    localparam logic [2:0] PH_VALUE  = 3'd4;
    localparam logic [2:0] PH_ESC    = 3'd5;
    localparam logic [2:0] PH_QDROP  = 3'd6;
    localparam logic [2:0] PH_STOP   = 3'd7;

    localparam logic [2:0] PH_FIRST_KEY = (KEY_LEN - 1 <= 1) ? PH_KDROP : PH_KEY;

    logic [2:0]     phase_reg, phase_next;
    logic           quoted_reg, quoted_next;
    logic [KCW-1:0] kc_reg, kc_next;
    logic [VCW-1:0] vc_reg, vc_next;
    logic [PW-1:0]  pend_reg, pend_next;

    logic           accept;
    logic           key_wr_possible;
    logic           is_ws;
    logic           do_vchar;
    logic           do_vbyte;
    logic           term;
    logic           eff_q;
    logic [VCW-1:0] eff_vc;
    logic [VCW-1:0] vc_inc;
    logic [KCW-1:0] kc_inc;
    logic [7:0]     vbyte;
    cmd_t           cmd_c;

    assign key_wr_possible = (phase_reg == PH_SKIP) || (phase_reg == PH_KEY) ||
                             ((phase_reg == PH_VALUE) && quoted_reg && (vc_reg == '0));
    assign s_tready = !q_full && !(key_wr_possible && (pend_reg != '0));
    assign accept   = s_tvalid && s_tready;
    assign is_ws    = (s_tdata == CH_SP) || ((s_tdata >= CH_TAB) && (s_tdata <= CH_CR));
    assign kc_inc   = kc_reg + 1'b1;
    assign key_wdata = s_tdata;

    always_comb begin
        phase_next  = phase_reg;
        quoted_next = quoted_reg;
        kc_next     = kc_reg;
        vc_next     = vc_reg;
        cmd_c       = '0;
        key_we      = 1'b0;
        key_waddr   = kc_reg[KAW-1:0];
        do_vchar    = 1'b0;
        do_vbyte    = 1'b0;
        term        = 1'b0;
        vbyte       = s_tdata;
        eff_q       = quoted_reg;
        eff_vc      = vc_reg;
        vc_inc      = '0;

        case (phase_reg)
            PH_SKIP: begin
                if (!is_ws) begin
                    if (s_tdata == CH_EQ) begin
                        phase_next = PH_STOP;
                    end else begin
                        key_we     = 1'b1;
                        key_waddr  = '0;
                        kc_next    = KCW'(1);
                        vc_next    = '0;
                        phase_next = PH_FIRST_KEY;
                    end
                end
            end
            PH_KEY: begin
                if (s_tdata == CH_EQ) begin
                    phase_next = PH_VSTART;
                end else begin
                    key_we  = 1'b1;
                    kc_next = kc_inc;
                    if (kc_inc >= KCW'(KEY_LEN - 1)) begin
                        phase_next = PH_KDROP;
                    end
                end
            end
            PH_KDROP: begin
                phase_next = PH_VSTART;
            end
            PH_VSTART: begin
                vc_next    = '0;
                phase_next = PH_VALUE;
                if (s_tdata == CH_DQ) begin
                    quoted_next = 1'b1;
                end else begin
                    quoted_next = 1'b0;
                    eff_q       = 1'b0;
                    eff_vc      = '0;
                    do_vchar    = 1'b1;
                end
            end
            PH_VALUE: begin
                do_vchar = 1'b1;
            end
            PH_ESC: begin
                do_vbyte = 1'b1;
                if (s_tdata == CH_N) begin
                    vbyte = CH_LF;
                end else if (s_tdata == CH_R) begin
                    vbyte = CH_CR;
                end
            end
            PH_QDROP: begin
                phase_next = PH_SKIP;
            end
            default: begin
            end
        endcase

        if (do_vchar) begin
            term = eff_q ? (s_tdata == CH_DQ) : (s_tdata == CH_SP);
            if (term) begin
                if (eff_vc == '0) begin
                    phase_next = PH_SKIP;
                    if (eff_q) begin
                        key_we     = 1'b1;
                        key_waddr  = '0;
                        kc_next    = KCW'(1);
                        vc_next    = '0;
                        phase_next = PH_FIRST_KEY;
                    end
                end else begin
                    cmd_c.has_end = 1'b1;
                    vc_next       = '0;
                    kc_next       = '0;
                    phase_next    = PH_SKIP;
                end
            end else if (s_tdata == CH_BS) begin
                phase_next = PH_ESC;
            end else begin
                do_vbyte = 1'b1;
            end
        end

        if (do_vbyte) begin
            cmd_c.flush   = (eff_vc == '0);
            cmd_c.klen    = KLEN_W'(kc_reg);
            cmd_c.has_val = 1'b1;
            cmd_c.val     = vbyte;
            vc_inc        = eff_vc + 1'b1;
            if (vc_inc == VCW'(VALUE_LEN - 1)) begin
                cmd_c.has_end = 1'b1;
                vc_next       = '0;
                kc_next       = '0;
                phase_next    = eff_q ? PH_QDROP : PH_SKIP;
            end else begin
                vc_next    = vc_inc;
                phase_next = PH_VALUE;
            end
        end

        if (s_tlast) begin
            if (((phase_next == PH_VALUE) || (phase_next == PH_ESC)) && (vc_next != '0)) begin
                cmd_c.has_end = 1'b1;
            end
            phase_next  = PH_SKIP;
            quoted_next = 1'b0;
            kc_next     = '0;
            vc_next     = '0;
        end
    end

    assign cmd       = cmd_c;
    assign push      = accept && (cmd_c.has_val || cmd_c.has_end);
    assign pend_next = pend_reg + PW'(push && cmd_c.flush) - PW'(flush_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SKIP;
            quoted_reg <= 1'b0;
            kc_reg     <= '0;
            vc_reg     <= '0;
            pend_reg   <= '0;
        end else begin
            pend_reg <= pend_next;
            if (accept) begin
                phase_reg  <= phase_next;
                quoted_reg <= quoted_next;
                kc_reg     <= kc_next;
                vc_reg     <= vc_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_key_write_during_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && key_we) |-> (pend_reg == '0))
        else $error("Key store written while a key flush is pending.");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("Command pushed into a full queue.");

    a_pending_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PW'(QDEPTH))
        else $error("Pending flush count exceeds the queue depth.");

    a_flush_done_has_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_done |-> (pend_reg != '0))
        else $error("Flush finished with no flush pending.");
`endif

endmodule

@@ rtl/core/kvt_back.sv @@
// ----------------------------------------------------------------------------
// kvt_back
// Output sequencer: pops commands, replays the stored key from the key
// store for a command that opens a value, then sends the value byte and the
// pair end, where the command holds them, through the output register.
// ----------------------------------------------------------------------------
module kvt_back #(
    parameter int KAW = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  kvt_pkg::cmd_t       cmd,
    input  logic                q_empty,
    output logic                pop,
    output logic                flush_done,
    output logic [KAW-1:0]      key_raddr,
    input  logic [7:0]          key_rdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);

    import kvt_pkg::*;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_KREAD = 3'd1;
    localparam logic [2:0] B_KOUT  = 3'd2;
    localparam logic [2:0] B_VAL   = 3'd3;
    localparam logic [2:0] B_END   = 3'd4;

    logic [2:0]        state_reg, state_next;
    cmd_t              cur_reg, cur_next;
    logic [KLEN_W-1:0] idx_reg, idx_next;
    logic [KLEN_W-1:0] idx_inc;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        byte_reg, byte_next;
    logic [1:0]        kind_reg, kind_next;
    logic              last_reg, last_next;
    logic              out_free;
    logic              load;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign idx_inc   = idx_reg + 1'b1;
    assign key_raddr = idx_reg[KAW-1:0];

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        flush_done = 1'b0;
        load       = 1'b0;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;

        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    cur_next   = cmd;
                    idx_next   = '0;
                    state_next = (cmd.flush && (cmd.klen != '0)) ? B_KREAD : B_VAL;
                end
            end
            B_KREAD: begin
                state_next = B_KOUT;
            end
            B_KOUT: begin
                if (out_free) begin
                    load      = 1'b1;
                    byte_next = key_rdata;
                    kind_next = KIND_KEY;
                    last_next = 1'b0;
                    idx_next  = idx_inc;
                    if (idx_inc == cur_reg.klen) begin
                        flush_done = 1'b1;
                        state_next = B_VAL;
                    end else begin
                        state_next = B_KREAD;
                    end
                end
            end
            B_VAL: begin
                if (!cur_reg.has_val) begin
                    state_next = B_END;
                end else if (out_free) begin
                    load       = 1'b1;
                    byte_next  = cur_reg.val;
                    kind_next  = KIND_VALUE;
                    last_next  = !cur_reg.has_end;
                    state_next = cur_reg.has_end ? B_END : B_IDLE;
                end
            end
            B_END: begin
                if (out_free) begin
                    load       = 1'b1;
                    byte_next  = '0;
                    kind_next  = KIND_END;
                    last_next  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase

        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule
